// File: src/plccs_pkg.sv
// Shared types, constants and helper functions of the PLC command sequencer.
package plccs_pkg;

  // Width of the task tick counter.
  localparam int unsigned TicksW = 9;
  // Clamp applied to the scaled speed word.
  localparam logic [11:0] SPEED_CAP = 12'd4000;

  // Item modes on the input channel.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_RX    = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  // ASCII codes used by the receive side and the frame builder.
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_ONE    = 8'h31;
  localparam logic [7:0] CHAR_THREE  = 8'h33;

  // Frame prefixes.
  localparam logic [8*11-1:0] CSR_PREFIX  = "%01#WCSR000";
  localparam logic [8*17-1:0] DATA_PREFIX = "%01#WDD0010000101";

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_WITH_DATA  = 3'd0,
    CFG_DRIVE_MODE = 3'd1,
    CFG_TURN       = 3'd2,
    CFG_DATA_Q8    = 3'd3,
    CFG_SCALE_Q16  = 3'd4
  } cfg_reg_e;

  // Task kinds of both task lists.
  typedef enum logic [2:0] {
    TK_PLAY = 3'd0,
    TK_STOP = 3'd1,
    TK_PARM = 3'd2,
    TK_MODE = 3'd3,
    TK_TURN = 3'd4,
    TK_DATA = 3'd5,
    TK_TEST = 3'd6
  } task_kind_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } out_word_t;

  // Registers the frame builder reads.
  typedef struct packed {
    logic [3:0]  drive_mode_digit;
    logic [3:0]  turn_digit;
    logic [23:0] data_q8;
    logic [17:0] scale_q16;
  } frame_cfg_t;

  // Frame load request from the sequencer to the transmitter.
  typedef struct packed {
    logic       load;
    task_kind_e kind;
  } tx_req_t;

  // Task kind at a place of the active list.
  function automatic task_kind_e list_kind(input logic data_list, input logic [2:0] idx);
    task_kind_e k;
    k = TK_PLAY;
    if (data_list) begin
      unique case (idx)
        3'd0:    k = TK_PLAY;
        3'd1:    k = TK_MODE;
        3'd2:    k = TK_TURN;
        3'd3:    k = TK_DATA;
        3'd4:    k = TK_TEST;
        3'd5:    k = TK_PARM;
        default: k = TK_PLAY;
      endcase
    end else begin
      unique case (idx)
        3'd0:    k = TK_PLAY;
        3'd1:    k = TK_STOP;
        3'd2:    k = TK_PARM;
        default: k = TK_PLAY;
      endcase
    end
    return k;
  endfunction

  // Uppercase hex character of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = CHAR_ZERO + {4'h0, v};
    end else begin
      c = 8'h37 + {4'h0, v};
    end
    return c;
  endfunction

endpackage

// File: src/plc_command_sequencer.sv
// Top level of the PLC command sequencer: input register, task sequencer and config registers.
// An accepted item is registered and takes effect when it retires; items that send nothing go
// through at one per cycle. A frame's first word passes the input and word registers, then one
// word per cycle unless the output stalls (16 to 28 words), paced by the frame transmitter,
// which holds one frame; an item that sends a frame waits while an earlier one is still going
// out. Reset clears the sequencer state and loads the register defaults; no clearing pass.
module plc_command_sequencer #(
  parameter int unsigned RETRY_PERIOD  = 100,
  parameter int unsigned TIMEOUT_TICKS = 300
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [23:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  plccs_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output plccs_pkg::out_word_t out_word_o
);
  import plccs_pkg::*;

  localparam int unsigned RetryW = (RETRY_PERIOD > 1) ? $clog2(RETRY_PERIOD) : 1;
  localparam logic [RetryW-1:0]  RetryLast = RetryW'(RETRY_PERIOD - 1);
  localparam logic [TicksW-1:0]  Timeout   = TicksW'(TIMEOUT_TICKS);

  // Configuration registers.
  logic        with_data_q;
  frame_cfg_t  cfg_q;

  // Sequencer state.
  logic [2:0]        task_index_q, task_index_d;
  logic [TicksW-1:0] task_ticks_q, task_ticks_d;
  logic [RetryW-1:0] retry_q, retry_d;
  logic              ack_seen_q, ack_seen_d;
  logic              go_flag_q, go_flag_d;
  logic              data_list_q, data_list_d;
  logic              dollar_q, dollar_d;

  // Input register.
  logic     in_valid_q;
  in_word_t in_word_q;

  logic        tx_free;
  tx_req_t     req;
  logic        emit;
  task_kind_e  emit_kind;
  logic        commit;
  logic        accept;
  logic [2:0]  list_size;
  logic        in_range;
  task_kind_e  cur_kind;
  logic        advance;
  logic [2:0]  index_inc;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      with_data_q            <= 1'b0;
      cfg_q.drive_mode_digit <= '0;
      cfg_q.turn_digit       <= '0;
      cfg_q.data_q8          <= '0;
      cfg_q.scale_q16        <= 18'd131465;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WITH_DATA:  with_data_q            <= cfg_data_i[0];
        CFG_DRIVE_MODE: cfg_q.drive_mode_digit <= cfg_data_i[3:0];
        CFG_TURN:       cfg_q.turn_digit       <= cfg_data_i[3:0];
        CFG_DATA_Q8:    cfg_q.data_q8          <= cfg_data_i;
        CFG_SCALE_Q16:  cfg_q.scale_q16        <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // Task lookup for the current tick.
  assign list_size = data_list_q ? 3'd6 : 3'd3;
  assign in_range  = task_index_q < list_size;
  assign cur_kind  = list_kind(data_list_q, task_index_q);
  assign index_inc = task_index_q + 3'd1;

  // Does the held item send a frame, and which one.
  always_comb begin
    emit      = 1'b0;
    emit_kind = TK_STOP;
    if (in_word_q.mode == MODE_STOP) begin
      emit = 1'b1;
    end else if (in_word_q.mode == MODE_TICK && in_range && cur_kind != TK_PLAY &&
                 cur_kind != TK_PARM && retry_q == '0) begin
      emit      = 1'b1;
      emit_kind = cur_kind;
    end
  end

  // Handshake: the held item retires unless its frame must wait for the transmitter.
  assign commit     = in_valid_q && (!emit || tx_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !commit;
  assign req.load   = commit && emit;
  assign req.kind   = emit_kind;

  // Next sequencer state for the held item.
  always_comb begin
    task_index_d = task_index_q;
    task_ticks_d = task_ticks_q;
    retry_d      = retry_q;
    ack_seen_d   = ack_seen_q;
    go_flag_d    = go_flag_q;
    data_list_d  = data_list_q;
    dollar_d     = dollar_q;
    advance      = 1'b0;
    unique case (in_word_q.mode)
      MODE_TICK: begin
        if (!in_range) begin
          task_index_d = '0;
        end else begin
          if (cur_kind == TK_PLAY) begin
            advance = go_flag_q;
          end else if (cur_kind == TK_PARM) begin
            go_flag_d = 1'b0;
            advance   = 1'b1;
          end else if (ack_seen_q || task_ticks_q >= Timeout) begin
            task_ticks_d = '0;
            retry_d      = '0;
            ack_seen_d   = 1'b0;
            advance      = 1'b1;
          end else begin
            task_ticks_d = task_ticks_q + TicksW'(1);
            retry_d      = (retry_q == RetryLast) ? '0 : retry_q + RetryW'(1);
          end
          if (advance) begin
            task_index_d = (index_inc >= list_size) ? 3'd0 : index_inc;
          end
        end
      end
      MODE_START: begin
        data_list_d = with_data_q;
        go_flag_d   = 1'b1;
      end
      MODE_RX: begin
        if (in_word_q.rx_byte == CHAR_DOLLAR) begin
          dollar_d = 1'b1;
        end else if (in_word_q.rx_byte == CHAR_CR && dollar_q) begin
          ack_seen_d = 1'b1;
          dollar_d   = 1'b0;
        end
      end
      MODE_STOP: ;
    endcase
  end

  // Sequencer and input registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_index_q <= '0;
      task_ticks_q <= '0;
      retry_q      <= '0;
      ack_seen_q   <= 1'b0;
      go_flag_q    <= 1'b0;
      data_list_q  <= 1'b0;
      dollar_q     <= 1'b0;
      in_valid_q   <= 1'b0;
    end else begin
      if (commit) begin
        task_index_q <= task_index_d;
        task_ticks_q <= task_ticks_d;
        retry_q      <= retry_d;
        ack_seen_q   <= ack_seen_d;
        go_flag_q    <= go_flag_d;
        data_list_q  <= data_list_d;
        dollar_q     <= dollar_d;
      end
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (commit) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
  end

  plccs_frame_tx u_frame_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req),
    .free_o      (tx_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // A frame is loaded only when the transmitter can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) req.load |-> tx_free)
    else $error("frame loaded while transmitter busy");

  // The retry phase restarts together with the tick count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) task_ticks_q == '0 |-> retry_q == '0)
    else $error("retry phase out of step with tick count");

  // A frame stays valid until its carriage return is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && !out_stall_i && !out_word_o.last_byte |=> out_valid_o)
    else $error("frame ended before its last word");

  // The task index never leaves the range of the longer list.
  assert property (@(posedge clk_i) disable iff (!rst_ni) task_index_q < 3'd6)
    else $error("task index out of range");

endmodule

// File: src/plccs_frame_tx.sv
// Frame transmitter: builds a task's ASCII frame, sends a word per cycle unless stalled.
module plccs_frame_tx (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  plccs_pkg::frame_cfg_t cfg_i,
  input  plccs_pkg::tx_req_t   req_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output plccs_pkg::out_word_t out_word_o
);
  import plccs_pkg::*;

  logic        busy_q;
  task_kind_e  kind_q;
  logic [4:0]  idx_q;
  logic [41:0] prod_q;

  logic [7:0]  body [32];
  logic [4:0]  body_len;
  logic [3:0]  digit;
  logic [11:0] speed;
  logic [15:0] torque;
  logic        last;
  logic        done;

  // Speed product, registered ahead of the clamp.
  always_ff @(posedge clk_i) begin
    prod_q <= 42'(cfg_i.data_q8) * 42'(cfg_i.scale_q16);
  end

  // Clamped speed word and torque word, zero unless the drive mode picks them.
  always_comb begin
    speed  = '0;
    torque = '0;
    if (cfg_i.drive_mode_digit == 4'd0) begin
      if (prod_q[41:24] > {6'd0, SPEED_CAP}) begin
        speed = SPEED_CAP;
      end else begin
        speed = prod_q[35:24];
      end
    end
    if (cfg_i.drive_mode_digit == 4'd1) begin
      torque = cfg_i.data_q8[23:8];
    end
  end

  // Frame body ahead of the common tail.
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      body[i] = 8'h00;
    end
    for (int i = 0; i < 11; i++) begin
      body[i] = CSR_PREFIX[8*(10-i) +: 8];
    end
    digit    = (kind_q == TK_MODE) ? cfg_i.drive_mode_digit : cfg_i.turn_digit;
    body_len = 5'd13;
    unique case (kind_q)
      TK_MODE, TK_TURN: begin
        body[11] = (kind_q == TK_MODE) ? CHAR_ONE : CHAR_THREE;
        if (digit >= 4'd10) begin
          body[12] = CHAR_ONE;
          body[13] = CHAR_ZERO + {4'h0, digit - 4'd10};
          body_len = 5'd14;
        end else begin
          body[12] = CHAR_ZERO + {4'h0, digit};
          body_len = 5'd13;
        end
      end
      TK_DATA: begin
        for (int i = 0; i < 17; i++) begin
          body[i] = DATA_PREFIX[8*(16-i) +: 8];
        end
        body[17] = hex_char(speed[7:4]);
        body[18] = hex_char(speed[3:0]);
        body[19] = hex_char(4'h0);
        body[20] = hex_char(speed[11:8]);
        body[21] = hex_char(torque[7:4]);
        body[22] = hex_char(torque[3:0]);
        body[23] = hex_char(torque[15:12]);
        body[24] = hex_char(torque[11:8]);
        body_len = 5'd25;
      end
      TK_TEST: begin
        body[11] = CHAR_ZERO;
        body[12] = CHAR_ONE;
      end
      default: begin
        // Stop frame; the other kinds never reach the transmitter.
        body[11] = CHAR_ZERO;
        body[12] = CHAR_ZERO;
      end
    endcase
  end

  // Select the current word: body, then two stars and the carriage return.
  always_comb begin
    last = (idx_q == body_len + 5'd2);
    if (idx_q < body_len) begin
      out_word_o.tx_byte = body[idx_q];
    end else if (last) begin
      out_word_o.tx_byte = CHAR_CR;
    end else begin
      out_word_o.tx_byte = CHAR_STAR;
    end
    out_word_o.last_byte = last;
  end

  assign out_valid_o = busy_q;
  assign done        = busy_q && !out_stall_i && last;
  assign free_o      = !busy_q || done;

  // Word counter of the frame in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= TK_STOP;
      idx_q  <= '0;
    end else if (req_i.load) begin
      busy_q <= 1'b1;
      kind_q <= req_i.kind;
      idx_q  <= '0;
    end else if (busy_q && !out_stall_i) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 5'd1;
      end
    end
  end

endmodule

// File: test/plccs_frame_checker.sv
// Checker that mirrors the PLC command sequencer and compares every transmitted frame word.
module plccs_frame_checker #(
  parameter int unsigned RETRY_PERIOD  = 100,
  parameter int unsigned TIMEOUT_TICKS = 300
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [23:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  plccs_pkg::in_word_t  in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  plccs_pkg::out_word_t out_word_i,
  output int                   mismatch_cnt_o,
  output int                   pending_o,
  output int                   words_in_o,
  output int                   words_out_o
);
  import plccs_pkg::*;

  localparam logic [17:0] SPEED_LIMIT = 18'd4000;

  // Mirrored sequencer state.
  logic [2:0] task_idx;
  logic [8:0] task_tick;
  logic       ack_pend;
  logic       go_flag;
  logic       data_list;
  logic       dollar_pend;

  // Mirrored configuration registers.
  logic        with_data;
  logic [3:0]  mode_digit;
  logic [3:0]  turn_digit;
  logic [23:0] setpoint_q8;
  logic [17:0] scale_q16;

  // Frame words still owed by the block, oldest first.
  out_word_t frame_words_q[$];
  out_word_t want_word;
  int        mismatch_cnt;
  int        words_in;
  int        words_out;

  function automatic void push_char(input logic [7:0] c, input logic last);
    out_word_t w;
    w.tx_byte   = c;
    w.last_byte = last;
    frame_words_q.push_back(w);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], 1'b0);
    end
  endfunction

  // Digits of ten and above come out as a leading one and the units digit.
  function automatic void push_digit(input logic [3:0] v);
    logic [3:0] units;
    units = v;
    if (v >= 4'd10) begin
      push_char(8'h31, 1'b0);
      units = v - 4'd10;
    end
    push_char(8'h30 + {4'h0, units}, 1'b0);
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    logic [7:0] c;
    if (v > 4'd9) begin
      c = 8'h41 + {4'h0, v - 4'd10};
    end else begin
      c = 8'h30 + {4'h0, v};
    end
    return c;
  endfunction

  function automatic void push_hex(input logic [7:0] v);
    push_char(nibble_char(v[7:4]), 1'b0);
    push_char(nibble_char(v[3:0]), 1'b0);
  endfunction

  // Appends the whole frame of one command to the expected words.
  function automatic void queue_frame(input task_kind_e kind);
    logic [41:0] prod;
    logic [15:0] speed;
    logic [15:0] torque;
    speed  = '0;
    torque = '0;
    case (kind)
      TK_MODE: begin
        push_text("%01#WCSR0001");
        push_digit(mode_digit);
      end
      TK_TURN: begin
        push_text("%01#WCSR0003");
        push_digit(turn_digit);
      end
      TK_DATA: begin
        prod = {18'd0, setpoint_q8} * {24'd0, scale_q16};
        if (mode_digit == 4'd0) begin
          speed = (prod[41:24] > SPEED_LIMIT) ? SPEED_LIMIT[15:0] : prod[39:24];
        end
        if (mode_digit == 4'd1) begin
          torque = setpoint_q8[23:8];
        end
        push_text("%01#WDD0010000101");
        push_hex(speed[7:0]);
        push_hex(speed[15:8]);
        push_hex(torque[7:0]);
        push_hex(torque[15:8]);
      end
      TK_TEST: push_text("%01#WCSR00001");
      default: push_text("%01#WCSR00000");
    endcase
    push_char(CHAR_STAR, 1'b0);
    push_char(CHAR_STAR, 1'b0);
    push_char(CHAR_CR, 1'b1);
  endfunction

  function automatic task_kind_e kind_at(input logic use_data, input logic [2:0] idx);
    task_kind_e k;
    if (use_data) begin
      case (idx)
        3'd0:    k = TK_PLAY;
        3'd1:    k = TK_MODE;
        3'd2:    k = TK_TURN;
        3'd3:    k = TK_DATA;
        3'd4:    k = TK_TEST;
        default: k = TK_PARM;
      endcase
    end else begin
      case (idx)
        3'd0:    k = TK_PLAY;
        3'd1:    k = TK_STOP;
        default: k = TK_PARM;
      endcase
    end
    return k;
  endfunction

  // One timer tick: run the current task and step through the list.
  function automatic void run_tick();
    logic [2:0] list_len;
    task_kind_e kind;
    logic       step;
    list_len = data_list ? 3'd6 : 3'd3;
    step     = 1'b0;
    if (task_idx >= list_len) begin
      // A list switch left the index past the end; it wraps silently.
      task_idx = '0;
      return;
    end
    kind = kind_at(data_list, task_idx);
    if (kind == TK_PLAY) begin
      step = go_flag;
    end else if (kind == TK_PARM) begin
      go_flag = 1'b0;
      step    = 1'b1;
    end else begin
      if (task_tick % RETRY_PERIOD == 0) begin
        queue_frame(kind);
      end
      if (ack_pend || task_tick >= TIMEOUT_TICKS) begin
        task_tick = '0;
        ack_pend  = 1'b0;
        step      = 1'b1;
      end else begin
        task_tick = task_tick + 9'd1;
      end
    end
    if (step) begin
      task_idx = (task_idx + 3'd1 >= list_len) ? 3'd0 : task_idx + 3'd1;
    end
  endfunction

  // Predict on accepted input words, check accepted output words.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_idx       = '0;
      task_tick      = '0;
      ack_pend       = 1'b0;
      go_flag        = 1'b0;
      data_list      = 1'b0;
      dollar_pend    = 1'b0;
      with_data      = 1'b0;
      mode_digit     = '0;
      turn_digit     = '0;
      setpoint_q8    = '0;
      scale_q16      = 18'd131465;
      frame_words_q.delete();
      mismatch_cnt   = 0;
      words_in       = 0;
      words_out      = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
      words_in_o     <= 0;
      words_out_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WITH_DATA:  with_data   = cfg_data_i[0];
          CFG_DRIVE_MODE: mode_digit  = cfg_data_i[3:0];
          CFG_TURN:       turn_digit  = cfg_data_i[3:0];
          CFG_DATA_Q8:    setpoint_q8 = cfg_data_i;
          CFG_SCALE_Q16:  scale_q16   = cfg_data_i[17:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        words_in++;
        case (in_word_i.mode)
          MODE_TICK: run_tick();
          MODE_START: begin
            data_list = with_data;
            go_flag   = 1'b1;
          end
          MODE_RX: begin
            if (in_word_i.rx_byte == CHAR_DOLLAR) begin
              dollar_pend = 1'b1;
            end else if (in_word_i.rx_byte == CHAR_CR && dollar_pend) begin
              ack_pend    = 1'b1;
              dollar_pend = 1'b0;
            end
          end
          default: queue_frame(TK_STOP);
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (frame_words_q.size() == 0) begin
          $display("%0t: unexpected frame word: expected none, got tx_byte %h last_byte %b",
                   $time, out_word_i.tx_byte, out_word_i.last_byte);
          mismatch_cnt++;
        end else begin
          want_word = frame_words_q.pop_front();
          if (out_word_i.tx_byte !== want_word.tx_byte) begin
            $display("%0t: frame word %0d tx_byte: expected %h, got %h",
                     $time, words_out, want_word.tx_byte, out_word_i.tx_byte);
            mismatch_cnt++;
          end
          if (out_word_i.last_byte !== want_word.last_byte) begin
            $display("%0t: frame word %0d last_byte: expected %b, got %b",
                     $time, words_out, want_word.last_byte, out_word_i.last_byte);
            mismatch_cnt++;
          end
        end
        words_out++;
      end

      mismatch_cnt_o <= mismatch_cnt;
      pending_o      <= frame_words_q.size();
      words_in_o     <= words_in;
      words_out_o    <= words_out;
    end
  end

endmodule

// File: test/testbench.sv
// Top of the PLC command sequencer testbench: clock, reset, stimulus and verdict.
module testbench;
  import plccs_pkg::*;

  localparam int unsigned RETRY_PERIOD   = 100;
  localparam int unsigned TIMEOUT_TICKS  = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_WORDS   = 150;
  localparam int          DRAIN_CYCLES   = 10;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;

  int   mismatch_cnt;
  int   pending;
  int   words_in;
  int   words_out;
  int   random_words;
  int   settings;
  int   quiet_cycles;
  int   stall_left;
  logic counting;
  logic calm;
  logic cur_with_data;

  always #5 clk = ~clk;

  plc_command_sequencer #(
    .RETRY_PERIOD (RETRY_PERIOD),
    .TIMEOUT_TICKS(TIMEOUT_TICKS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  plccs_frame_checker #(
    .RETRY_PERIOD (RETRY_PERIOD),
    .TIMEOUT_TICKS(TIMEOUT_TICKS)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending),
    .words_in_o    (words_in),
    .words_out_o   (words_out)
  );

  // Output stall comes in random bursts, never once the run turns calm.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // End the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d frame words outstanding",
               $time, quiet_cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one input word and hold it until it is taken, sometimes after an idle burst.
  task automatic send_word(input logic [1:0] mode, input logic [7:0] rx);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{mode: mode, rx_byte: rx};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counting) begin
      random_words++;
    end
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Stop sending until every owed frame word is out and the pipeline has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [23:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic wd, input logic [3:0] dm, input logic [3:0] td,
                           input logic [23:0] sp, input logic [17:0] sc);
    write_reg(CFG_WITH_DATA, {23'd0, wd});
    write_reg(CFG_DRIVE_MODE, {20'd0, dm});
    write_reg(CFG_TURN, {20'd0, td});
    write_reg(CFG_DATA_Q8, sp);
    write_reg(CFG_SCALE_Q16, {6'd0, sc});
    cur_with_data = wd;
    settings++;
  endtask

  // A dollar sign then a carriage return, sometimes with a stray byte between.
  task automatic send_ack();
    send_word(MODE_RX, CHAR_DOLLAR);
    if ($urandom_range(0, 5) == 0) begin
      send_word(MODE_RX, any_byte());
    end
    send_word(MODE_RX, CHAR_CR);
  endtask

  task automatic send_noise();
    logic [1:0] mode;
    int         r;
    logic [7:0] rx;
    mode = 2'($urandom_range(0, 3));
    r    = $urandom_range(0, 3);
    rx   = (r == 0) ? CHAR_DOLLAR : (r == 1) ? CHAR_CR : any_byte();
    send_word(mode, rx);
  endtask

  // Start, leave the wait task, then step the command tasks with acks, extra ticks or noise.
  task automatic run_sequence(input logic use_data);
    int steps;
    int pick;
    steps = use_data ? 5 : 2;
    send_word(MODE_START, any_byte());
    send_word(MODE_TICK, any_byte());
    for (int s = 0; s < steps; s++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_ack();
        send_word(MODE_TICK, any_byte());
      end else if (pick < 8) begin
        send_word(MODE_TICK, any_byte());
        send_ack();
        send_word(MODE_TICK, any_byte());
      end else if (pick == 8) begin
        repeat ($urandom_range(2, 6)) send_word(MODE_TICK, any_byte());
      end else begin
        send_noise();
        send_word(MODE_TICK, any_byte());
      end
      if ($urandom_range(0, 19) == 0) begin
        wait_drained();
      end
    end
  endtask

  // Random register setting, with the extremes drawn often.
  task automatic pick_settings();
    logic       wd;
    logic [3:0] dm;
    logic [3:0] td;
    logic [23:0] sp;
    logic [17:0] sc;
    int         r;
    wait_drained();
    wd = ($urandom_range(0, 3) != 0);
    r  = $urandom_range(0, 9);
    dm = (r < 4) ? 4'd0 : (r < 7) ? 4'd1 : 4'($urandom_range(0, 15));
    td = 4'($urandom_range(0, 15));
    r  = $urandom_range(0, 3);
    sp = (r == 0) ? 24'd0 : (r == 1) ? 24'hFFFFFF :
         (r == 2) ? 24'($urandom) : 24'($urandom_range(0, 24'h3FFFF));
    r  = $urandom_range(0, 3);
    sc = (r == 0) ? 18'd0 : (r == 1) ? 18'h3FFFF :
         (r == 2) ? 18'd131465 : 18'($urandom);
    write_all(wd, dm, td, sp, sc);
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_WITH_DATA;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_word       = '0;
    quiet_cycles  = 0;
    random_words  = 0;
    settings      = 0;
    counting      = 1'b0;
    calm          = 1'b0;
    cur_with_data = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short list at the reset settings: stop event, idle ticks, an ack after a stray
    // carriage return and a repeated dollar sign.
    send_word(MODE_STOP, 8'hFF);
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_RX, CHAR_CR);
    send_word(MODE_START, 8'h00);
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_RX, CHAR_DOLLAR);
    send_word(MODE_RX, CHAR_DOLLAR);
    send_word(MODE_RX, CHAR_CR);
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_TICK, 8'h00);

    // Data list with the capped speed word and a two-digit turn contact.
    wait_drained();
    write_all(1'b1, 4'd0, 4'd15, 24'hFFFFFF, 18'h3FFFF);
    send_word(MODE_START, 8'h00);
    send_word(MODE_TICK, 8'h00);
    send_ack();
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_TICK, 8'h00);
    send_ack();
    send_word(MODE_TICK, 8'h00);
    send_ack();
    send_word(MODE_TICK, 8'h00);

    // Switch to the short list while the index points past its end.
    wait_drained();
    write_reg(CFG_WITH_DATA, 24'd0);
    cur_with_data = 1'b0;
    send_word(MODE_START, 8'h00);
    send_word(MODE_TICK, 8'h00);

    // Stop task left without an acknowledge for a full retry period, so its frame goes out
    // again; a late acknowledge then moves it on.
    send_word(MODE_START, any_byte());
    send_word(MODE_TICK, any_byte());
    repeat (RETRY_PERIOD + 1) send_word(MODE_TICK, any_byte());
    send_ack();
    send_word(MODE_TICK, any_byte());
    send_word(MODE_TICK, any_byte());

    // Random phases, each under its own register setting.
    counting = 1'b1;
    while (random_words < RANDOM_WORDS) begin
      if (random_words > RANDOM_WORDS - 50) begin
        calm <= 1'b1;
      end
      pick_settings();
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 5)) send_noise();
        end else begin
          run_sequence(cur_with_data);
        end
      end
    end

    wait_drained();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d input words and checked %0d frame words over %0d register settings,",
             words_in, words_out, settings);
    $display("with list switches mid-sequence, a retried frame, stop events and stray bytes.");
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d frame words never sent", mismatch_cnt, pending);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
